// ===== sv/aspid_pkg.sv =====
`timescale 1ns / 1ps
// Package for the AS path identifier block: CRC-32 constants and helper functions.
// No dependencies; imported by as_path_id_hex_crc.

package aspid_pkg;

	localparam int unsigned HEX_DIGITS = 8;
	localparam int unsigned STR_W      = 8 * HEX_DIGITS;

	localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_FINAL = 32'hFFFF_FFFF;
	localparam logic [7:0]  STR_TERM  = 8'h00;

	// Reflected CRC-32 update by one byte, one polynomial step per bit.
	function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] data);
		logic [31:0] c;
		c = crc_in ^ {24'h0, data};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// Upper-case hex ASCII for one nibble.
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		return (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h37 + {4'h0, nib});
	endfunction

	// Render a word as eight hex characters, most significant nibble in the top byte.
	function automatic logic [STR_W-1:0] render_hex(input logic [31:0] word);
		logic [STR_W-1:0] s;
		s = '0;
		for (int i = 0; i < HEX_DIGITS; i++) begin
			s[8*i +: 8] = hex_char(word[4*i +: 4]);
		end
		return s;
	endfunction

	function automatic logic [31:0] swap32(input logic [31:0] w);
		return {w[7:0], w[15:8], w[23:16], w[31:24]};
	endfunction

	// Identifier of an empty path: the terminator byte alone.
	localparam logic [31:0] EMPTY_ID = crc_byte(CRC_INIT, STR_TERM) ^ CRC_FINAL;

endpackage

// ===== sv/as_path_id_hex_crc.sv =====
`timescale 1ns / 1ps
// AS path identifier: CRC-32 over the upper-case hex text of an AS path.
// Depends on aspid_pkg (constants, hex rendering and CRC byte update).
//
//  Channel   Handshake             Payload                          Direction
//  ------    --------------------  -------------------------------  ---------
//  input     in_valid / in_ready   asn_word, last_word, path_empty  into block
//  output    out_valid / out_ready path_id                          out of block
//  config    cfg_wen               cfg_wdata (byte_swap)            into block
//
// Flow: one request per cycle while the output accepts results. A request is
// byte-swapped if byte_swap is set, then rendered to eight hex characters before
// the stage-1 register; the 8- or 9-byte CRC update runs as one XOR network
// between stage 1 and the result register, which takes the path ID of a final word.
// Reset: arst_n clears both valids, the running CRC to all ones and byte_swap.
// Stalls: when the result register holds an unread ID and out_ready is low, a
// final word or empty-path request waits in stage 1; non-final words keep flowing through.

module as_path_id_hex_crc (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] asn_word,
	input  logic        last_word,
	input  logic        path_empty,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] path_id
);
	import aspid_pkg::*;

	logic              byte_swap_q;

	// Stage 1: rendered hex text and flags of one request.
	logic              valid_s1;
	logic [STR_W-1:0]  text_s1;
	logic              last_s1;
	logic              empty_s1;

	logic [31:0]       crc_q;
	logic              out_valid_q;
	logic [31:0]       path_id_q;

	logic              res_s1;
	logic              out_free;
	logic              adv_s1;
	logic              in_take;
	logic [STR_W-1:0]  text_in;
	logic [31:0]       crc_word;
	logic [31:0]       crc_term;

	// A stage-1 request producing a result needs the result register free;
	// a non-final word only updates the running CRC and always moves on.
	assign res_s1   = last_s1 | empty_s1;
	assign out_free = ~out_valid_q | out_ready;
	assign adv_s1   = valid_s1 & (~res_s1 | out_free);
	assign in_ready = ~valid_s1 | adv_s1;
	assign in_take  = in_valid & in_ready;

	// Sample byte_swap per word, at acceptance.
	assign text_in = render_hex(byte_swap_q ? swap32(asn_word) : asn_word);

	// Feed the eight characters, first character first, then the terminator.
	always_comb begin
		crc_word = crc_q;
		for (int i = HEX_DIGITS - 1; i >= 0; i--) begin
			crc_word = crc_byte(crc_word, text_s1[8*i +: 8]);
		end
		crc_term = crc_byte(crc_word, STR_TERM);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_swap_q <= 1'b0;
		end else if (cfg_wen) begin
			byte_swap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			text_s1  <= text_in;
			last_s1  <= last_word;
			empty_s1 <= path_empty;
		end
	end

	// Running CRC: advance on a middle word, return to all ones at path end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (adv_s1) begin
			crc_q <= res_s1 ? CRC_INIT : crc_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv_s1 & res_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && adv_s1 && res_s1) begin
			path_id_q <= empty_s1 ? EMPTY_ID : (crc_term ^ CRC_FINAL);
		end
	end

	assign out_valid = out_valid_q;
	assign path_id   = path_id_q;

	// An empty path yields the terminator-only ID.
	a_empty_id: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && empty_s1 |=> out_valid_q && path_id_q == EMPTY_ID)
		else $error("empty path did not yield terminator-only ID");

	// The running CRC restarts after every path end.
	a_crc_restart: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && res_s1 |=> crc_q == CRC_INIT)
		else $error("running CRC not restarted after path end");

	// A middle word never disturbs a waiting result.
	a_mid_word_keeps_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && !res_s1 && out_valid_q && !out_ready |=> out_valid_q && $stable(path_id_q))
		else $error("middle word disturbed pending path ID");

	// A blocked stage 1 takes no new request.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |-> !in_ready)
		else $error("request accepted while stage 1 stalled");

	// The CRC holds while stage 1 is blocked.
	a_crc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> $stable(crc_q))
		else $error("running CRC changed during stall");

endmodule
